// File: design/gcfd_pkg.sv
// Shared types and constants for the gimbal command frame decoder.
`default_nettype none
package gcfd_pkg;

   localparam int STORE_DEPTH = 15;
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int ECHO_COUNT  = 6;

   localparam logic [7:0] SOF_BYTE  = 8'hAB;
   localparam logic [7:0] EOF_BYTE  = 8'hBA;
   localparam logic [7:0] INIT_BYTE = 8'hCC;

   localparam logic [31:0] LOWER_RESET = 32'h0001_2158;
   localparam logic [31:0] UPPER_RESET = 32'h0001_A4FC;
   localparam logic [31:0] NEAR_LIMIT  = 32'h0000_0010;
   localparam logic [14:0] PITCH_GAIN  = 15'd25000;
   localparam int          GAIN_SHIFT  = 17;

   localparam logic       REG_LOWER = 1'b0;
   localparam logic       REG_UPPER = 1'b1;
   localparam int         ADDR_W    = 3;

   localparam logic [3:0] SLOT_AZ    = 4'd6;
   localparam logic [3:0] SLOT_PITCH = 4'd7;
   localparam logic [3:0] SLOT_CCD   = 4'd8;

   typedef enum logic [2:0] {
      KIND_ECHO  = 3'd0,
      KIND_INIT  = 3'd1,
      KIND_AZ    = 3'd2,
      KIND_PITCH = 3'd3,
      KIND_CCD   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [STORE_DEPTH-1:0][7:0] bytes;
      logic [31:0]                 actual_position;
   } frame_type;

endpackage
`default_nettype wire

// File: design/gcfd_if.sv
// Handshake channel interfaces for received bytes and decoded results.
`default_nettype none
interface gcfd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] actual_position;

   modport source (output valid, rx_byte, actual_position, input ready);
   modport sink (input valid, rx_byte, actual_position, output ready);
endinterface

interface gcfd_rsp_if;
   logic               valid;
   logic               ready;
   gcfd_pkg::kind_type kind;
   logic [7:0]         echo_byte;
   logic [31:0]        target_position;
   logic signed [15:0] target_speed;
   logic               lamp_off;
   logic               last;

   modport source (output valid, kind, echo_byte, target_position, target_speed,
                   lamp_off, last, input ready);
   modport sink (input valid, kind, echo_byte, target_position, target_speed,
                 lamp_off, last, output ready);
endinterface
`default_nettype wire

// File: design/gcfd_front.sv
// Frame parser: collects bytes into the store and hands closed frames on.
`default_nettype none
module gcfd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   gcfd_req_if.sink                 req_chan,
   output gcfd_pkg::frame_type      frame_out,
   output logic                     push,
   input  wire logic                push_ready
);
   import gcfd_pkg::*;

   logic                        in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [STORE_DEPTH-1:0][7:0] store_ff, store_in;
   logic                        accept;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      store_in    = store_ff;
      push        = 1'b0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_chan.rx_byte == SOF_BYTE) begin
               in_frame_in = 1'b1;
               count_in    = '0;
            end
         end else if (req_chan.rx_byte == EOF_BYTE) begin
            in_frame_in = 1'b0;
            push        = 1'b1;
         end else if (count_ff < COUNT_W'(STORE_DEPTH)) begin
            store_in[count_ff[$clog2(STORE_DEPTH)-1:0]] = req_chan.rx_byte;
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign frame_out.bytes           = store_ff;
   assign frame_out.actual_position = req_chan.actual_position;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         store_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         store_ff    <= store_in;
      end
   end

endmodule
`default_nettype wire

// File: design/gcfd_queue.sv
// Short frame queue between the parser and the result sequencer.
`default_nettype none
module gcfd_queue #(
   parameter int QUEUE_DEPTH = gcfd_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gcfd_pkg::frame_type in_data,
   input  wire logic                in_push,
   output logic                     in_ready,
   output gcfd_pkg::frame_type      out_data,
   output logic                     out_valid,
   input  wire logic                out_pop
);
   import gcfd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   frame_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign in_ready  = cnt_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = in_push && in_ready;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: design/gcfd_back.sv
// Result sequencer: echoes a frame, then emits init or the three moves.
`default_nettype none
module gcfd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gcfd_pkg::frame_type frame_in,
   input  wire logic                frame_valid,
   output logic                     frame_pop,
   input  wire logic [31:0]         lower_bound,
   input  wire logic [31:0]         upper_bound,
   gcfd_rsp_if.source               rsp_chan
);
   import gcfd_pkg::*;

   frame_type   frame_ff;
   logic        busy_ff, busy_in;
   logic [3:0]  slot_ff, slot_in;
   logic        emit, is_init, is_last;

   logic        neg_ff, near_ff;
   logic [31:0] pos_ff, prod_ff, pitch_ff;
   logic [31:0] lo_diff, lo_back, up_diff, up_back, diff, step, pitch_in;
   logic        near_in;

   logic               out_valid_ff, out_valid_in;
   kind_type           kind_ff, kind_in;
   logic [7:0]         echo_ff, echo_in;
   logic [31:0]        tpos_ff, tpos_in;
   logic signed [15:0] tspd_ff, tspd_in;
   logic               lamp_ff, lamp_in;
   logic               last_ff, last_in;

   function automatic logic [31:0] sext16(input logic [7:0] hi, input logic [7:0] lo);
      return {{16{hi[7]}}, hi, lo};
   endfunction

   assign is_init = (frame_ff.bytes[0] == INIT_BYTE) && (frame_ff.bytes[1] == INIT_BYTE)
                 && (frame_ff.bytes[2] == INIT_BYTE) && (frame_ff.bytes[3] == INIT_BYTE)
                 && (frame_ff.bytes[4] == INIT_BYTE) && (frame_ff.bytes[5] == INIT_BYTE);

   assign frame_pop = !busy_ff && frame_valid;
   assign emit      = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign is_last   = (slot_ff == SLOT_CCD) || (slot_ff == SLOT_AZ && is_init);

   // pitch clamp: operands, then product, then limit
   always_comb begin
      lo_diff = frame_ff.actual_position - lower_bound;
      lo_back = lower_bound - frame_ff.actual_position;
      up_diff = upper_bound - frame_ff.actual_position;
      up_back = frame_ff.actual_position - upper_bound;
      if (frame_ff.bytes[6][7]) begin
         near_in = (lo_diff < NEAR_LIMIT) || (lo_back < NEAR_LIMIT);
         diff    = lo_diff;
      end else begin
         near_in = (up_diff < NEAR_LIMIT) || (up_back < NEAR_LIMIT);
         diff    = up_diff;
      end
   end

   always_comb begin
      step = prod_ff >> GAIN_SHIFT;
      if (neg_ff) begin
         step     = 32'd0 - step;
         pitch_in = (pos_ff < step) ? step : pos_ff;
      end else begin
         pitch_in = (pos_ff > step) ? step : pos_ff;
      end
      if (near_ff) begin
         pitch_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= frame_ff.bytes[6][7];
      near_ff  <= near_in;
      pos_ff   <= sext16(frame_ff.bytes[6], frame_ff.bytes[7]);
      prod_ff  <= 32'(diff * {17'd0, PITCH_GAIN});
      pitch_ff <= pitch_in;
   end

   always_comb begin
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      kind_in      = kind_ff;
      echo_in      = echo_ff;
      tpos_in      = tpos_ff;
      tspd_in      = tspd_ff;
      lamp_in      = lamp_ff;
      last_in      = last_ff;
      if (frame_pop) begin
         busy_in = 1'b1;
         slot_in = '0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         slot_in      = slot_ff + 1'b1;
         busy_in      = !is_last;
         echo_in      = '0;
         tpos_in      = '0;
         tspd_in      = '0;
         lamp_in      = 1'b0;
         last_in      = is_last;
         if (slot_ff < 4'(ECHO_COUNT)) begin
            kind_in = KIND_ECHO;
            echo_in = frame_ff.bytes[slot_ff];
         end else if (is_init) begin
            kind_in = KIND_INIT;
            lamp_in = 1'b1;
         end else if (slot_ff == SLOT_AZ) begin
            kind_in = KIND_AZ;
            tpos_in = sext16(frame_ff.bytes[1], frame_ff.bytes[2]);
            tspd_in = $signed({frame_ff.bytes[3], frame_ff.bytes[4]});
         end else if (slot_ff == SLOT_PITCH) begin
            kind_in = KIND_PITCH;
            tpos_in = pitch_ff;
            tspd_in = $signed({frame_ff.bytes[8], frame_ff.bytes[9]});
         end else begin
            kind_in = KIND_CCD;
            tpos_in = sext16(frame_ff.bytes[11], frame_ff.bytes[12]);
            tspd_in = $signed({frame_ff.bytes[13], frame_ff.bytes[14]});
            lamp_in = {frame_ff.bytes[11], frame_ff.bytes[12]} != 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         frame_ff <= frame_in;
      end
      slot_ff <= slot_in;
      kind_ff <= kind_in;
      echo_ff <= echo_in;
      tpos_ff <= tpos_in;
      tspd_ff <= tspd_in;
      lamp_ff <= lamp_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.kind            = kind_ff;
   assign rsp_chan.echo_byte       = echo_ff;
   assign rsp_chan.target_position = tpos_ff;
   assign rsp_chan.target_speed    = tspd_ff;
   assign rsp_chan.lamp_off        = lamp_ff;
   assign rsp_chan.last            = last_ff;

endmodule
`default_nettype wire

// File: design/gimbal_command_frame_decoder.sv
// Top level of the gimbal command frame decoder with its soft limit registers.
// The decoder takes one received byte per cycle. A closing byte hands the
// stored frame and the pitch feedback position to a queue of QUEUE_DEPTH
// frames; the sequencer behind it loads one frame and then emits one result
// per cycle while the receiver takes them (six echo items, then one init
// item or three moves) before it loads the next frame. Bytes are refused
// only while the queue is full. The pitch clamp uses one 32x15 multiplier
// whose result is ready well before the pitch item is emitted. The soft
// limit registers are at byte addresses 0 (lower) and 4 (upper).
`default_nettype none
module gimbal_command_frame_decoder #(
   parameter int QUEUE_DEPTH = gcfd_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   gcfd_req_if.sink                         req_chan,
   gcfd_rsp_if.source                       rsp_chan,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [gcfd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import gcfd_pkg::*;

   logic [31:0] lower_ff, upper_ff;
   logic        csr_write;
   frame_type   push_frame, pop_frame;
   logic        push, push_ready, pop, pop_valid;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_UPPER) ? upper_ff : lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOWER_RESET;
         upper_ff <= UPPER_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_LOWER: lower_ff <= pwdata;
            REG_UPPER: upper_ff <= pwdata;
            default:   lower_ff <= lower_ff;
         endcase
      end
   end

   gcfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .frame_out  (push_frame),
      .push       (push),
      .push_ready (push_ready)
   );

   gcfd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_data   (push_frame),
      .in_push   (push),
      .in_ready  (push_ready),
      .out_data  (pop_frame),
      .out_valid (pop_valid),
      .out_pop   (pop)
   );

   gcfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_in    (pop_frame),
      .frame_valid (pop_valid),
      .frame_pop   (pop),
      .lower_bound (lower_ff),
      .upper_bound (upper_ff),
      .rsp_chan    (rsp_chan)
   );

endmodule
`default_nettype wire

// File: verif/tb_gimbal_command_frame_decoder.sv
// Self-checking testbench for the gimbal command frame decoder: frames, echoes, moves, limits.
`default_nettype none
module tb_gimbal_command_frame_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import gcfd_pkg::*;

   localparam int                IDLE_LIMIT    = 2000;
   localparam int                SETTLE_CYCLES = 16;
   localparam int                HOLD_CYCLES   = 300;
   localparam logic [ADDR_W-1:0] LOWER_ADDR    = {REG_LOWER, 2'b00};
   localparam logic [ADDR_W-1:0] UPPER_ADDR    = {REG_UPPER, 2'b00};
   localparam logic [7:0]        LONG_FRAME [16] = '{
      SOF_BYTE, INIT_BYTE, INIT_BYTE, INIT_BYTE, INIT_BYTE, INIT_BYTE,
      8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h55
   };

   typedef struct {
      logic [7:0]  rx_byte;
      logic [31:0] actual_position;
   } rx_item_type;

   typedef struct {
      kind_type           kind;
      logic [7:0]         echo_byte;
      logic [31:0]        position;
      logic signed [15:0] speed;
      logic               lamp_off;
      logic               last;
   } command_type;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   gcfd_req_if req_chan ();
   gcfd_rsp_if rsp_chan ();

   gimbal_command_frame_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   rx_item_type rx_bytes [$];
   command_type expected_commands [$];
   rx_item_type next_rx;

   logic [31:0] lower_limit;
   logic [31:0] upper_limit;
   logic        frame_open;
   logic [3:0]  frame_len;
   logic [7:0]  frame_bytes [STORE_DEPTH];

   int          bytes_queued;
   int          bytes_taken;
   int          frames_closed;
   int          init_frames;
   int          commands_checked;
   int          mismatches;
   int          burst_left;
   int          gap_left;
   logic        steady;
   logic        long_stall_armed;
   logic        long_stall_taken;
   int          stall_left;
   logic [15:0] ready_pattern;
   logic [3:0]  pattern_pos;
   int          idle_cycles;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [31:0] widen(input logic [7:0] hi, input logic [7:0] lo);
      return {{16{hi[7]}}, hi, lo};
   endfunction

   function automatic logic [31:0] limit_pitch(input logic [31:0] pos, input logic [31:0] act);
      logic [31:0] diff;
      logic [31:0] prod;
      logic [31:0] step;
      if (pos[31]) begin
         if ((act - lower_limit) < NEAR_LIMIT || (lower_limit - act) < NEAR_LIMIT) return '0;
         diff = act - lower_limit;
         prod = diff * 32'd25000;
         step = 32'd0 - (prod >> GAIN_SHIFT);
         return (pos < step) ? step : pos;
      end
      if ((upper_limit - act) < NEAR_LIMIT || (act - upper_limit) < NEAR_LIMIT) return '0;
      diff = upper_limit - act;
      prod = diff * 32'd25000;
      step = prod >> GAIN_SHIFT;
      return (pos > step) ? step : pos;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic [31:0] act);
      logic        all_init;
      logic [31:0] ccd_pos;
      if (!frame_open) begin
         if (b == SOF_BYTE) begin
            frame_open = 1'b1;
            frame_len  = '0;
         end
      end else if (b != EOF_BYTE) begin
         if (frame_len < STORE_DEPTH) begin
            frame_bytes[frame_len] = b;
            frame_len++;
         end
      end else begin
         frame_open = 1'b0;
         frames_closed++;
         all_init = 1'b1;
         for (int i = 0; i < ECHO_COUNT; i++) begin
            expected_commands.push_back(
               command_type'{KIND_ECHO, frame_bytes[i], 32'd0, 16'sd0, 1'b0, 1'b0});
            if (frame_bytes[i] != INIT_BYTE) all_init = 1'b0;
         end
         if (all_init) begin
            init_frames++;
            expected_commands.push_back(
               command_type'{KIND_INIT, 8'd0, 32'd0, 16'sd0, 1'b1, 1'b1});
         end else begin
            expected_commands.push_back(command_type'{KIND_AZ, 8'd0,
               widen(frame_bytes[1], frame_bytes[2]),
               {frame_bytes[3], frame_bytes[4]}, 1'b0, 1'b0});
            expected_commands.push_back(command_type'{KIND_PITCH, 8'd0,
               limit_pitch(widen(frame_bytes[6], frame_bytes[7]), act),
               {frame_bytes[8], frame_bytes[9]}, 1'b0, 1'b0});
            ccd_pos = widen(frame_bytes[11], frame_bytes[12]);
            expected_commands.push_back(command_type'{KIND_CCD, 8'd0, ccd_pos,
               {frame_bytes[13], frame_bytes[14]}, ccd_pos[15:0] != 16'd0, 1'b1});
         end
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic [31:0] act);
      rx_bytes.push_back(rx_item_type'{b, act});
      bytes_queued++;
   endtask

   task automatic set_limit(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      psel   <= 1'b1;
      pwrite <= 1'b1;
      paddr  <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      if (addr == LOWER_ADDR) lower_limit = value;
      else upper_limit = value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== value)
         note_mismatch($sformatf("limit at %0d: expected %h, read %h", addr, value, readback));
   endtask

   task automatic queue_frames(input int min_items, input int min_frames);
      logic [7:0]  data [20];
      logic [7:0]  idle_byte;
      logic [31:0] close_pos;
      int          len;
      int          items;
      int          frames;
      items  = 0;
      frames = 0;
      while (items < min_items || frames < min_frames) begin
         if ($urandom_range(0, 4) == 0) begin
            idle_byte = 8'($urandom);
            if (idle_byte == SOF_BYTE) idle_byte = 8'h00;
            queue_byte(idle_byte, $urandom);
         end
         case ($urandom_range(0, 9))
            0, 1: len = $urandom_range(0, STORE_DEPTH - 1);
            2, 3: len = $urandom_range(STORE_DEPTH + 1, 20);
            default: len = STORE_DEPTH;
         endcase
         foreach (data[i]) data[i] = 8'($urandom);
         if ($urandom_range(0, 7) == 0)
            for (int i = 0; i < ECHO_COUNT; i++) data[i] = INIT_BYTE;
         if ($urandom_range(0, 3) == 0) begin
            data[11] = 8'h00;
            data[12] = 8'h00;
         end
         if ($urandom_range(0, 5) == 0) data[$urandom_range(0, 19)] = SOF_BYTE;
         case ($urandom_range(0, 4))
            0: close_pos = lower_limit + 32'($urandom_range(0, 40)) - 32'd20;
            1: close_pos = upper_limit + 32'($urandom_range(0, 40)) - 32'd20;
            2: close_pos = $urandom_range(lower_limit, upper_limit);
            default: close_pos = $urandom;
         endcase
         queue_byte(SOF_BYTE, $urandom);
         for (int i = 0; i < len; i++) queue_byte(data[i], $urandom);
         if ($urandom_range(0, 9) != 0) queue_byte(EOF_BYTE, close_pos);
         items += len + 2;
         frames++;
      end
   endtask

   task automatic drain();
      while (bytes_taken != bytes_queued || expected_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of items separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid           <= 1'b0;
         req_chan.rx_byte         <= '0;
         req_chan.actual_position <= '0;
         burst_left               <= 0;
         gap_left                 <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_byte(req_chan.rx_byte, req_chan.actual_position);
            bytes_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               gap_left       <= gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (rx_bytes.size() != 0) begin
               next_rx = rx_bytes.pop_front();
               req_chan.valid           <= 1'b1;
               req_chan.rx_byte         <= next_rx.rx_byte;
               req_chan.actual_position <= next_rx.actual_position;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= steady ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: one long hold-off on request, else a rotating ready pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready   <= 1'b0;
         long_stall_taken <= 1'b0;
         stall_left       <= 0;
         ready_pattern    <= '1;
         pattern_pos      <= '0;
      end else if (long_stall_armed && !long_stall_taken) begin
         long_stall_taken <= 1'b1;
         stall_left       <= HOLD_CYCLES;
         rsp_chan.ready   <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (pattern_pos == 0) begin
         if (steady) begin
            ready_pattern <= '1;
         end else begin
            case ($urandom_range(0, 3))
               0: ready_pattern <= '1;
               1: ready_pattern <= 16'($urandom);
               2: ready_pattern <= ~(16'($urandom) & 16'($urandom));
               default: ready_pattern <= 16'($urandom) & 16'($urandom);
            endcase
         end
         rsp_chan.ready <= 1'b1;
         pattern_pos    <= pattern_pos + 1'b1;
      end else begin
         rsp_chan.ready <= ready_pattern[pattern_pos];
         pattern_pos    <= pattern_pos + 1'b1;
      end
   end

   always @(posedge clock) begin
      command_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_commands.size() == 0) begin
            note_mismatch($sformatf("unexpected result: kind %0d echo %h pos %h speed %h",
               rsp_chan.kind, rsp_chan.echo_byte, rsp_chan.target_position,
               rsp_chan.target_speed));
         end else begin
            want = expected_commands.pop_front();
            commands_checked++;
            if (want.kind !== rsp_chan.kind || want.echo_byte !== rsp_chan.echo_byte ||
                want.position !== rsp_chan.target_position ||
                want.speed !== rsp_chan.target_speed ||
                want.lamp_off !== rsp_chan.lamp_off || want.last !== rsp_chan.last)
               note_mismatch({$sformatf(
                  "result %0d: expected kind %0d echo %h pos %h speed %h lamp %b last %b",
                  commands_checked, want.kind, want.echo_byte, want.position, want.speed,
                  want.lamp_off, want.last),
                  $sformatf(", got kind %0d echo %h pos %h speed %h lamp %b last %b",
                  rsp_chan.kind, rsp_chan.echo_byte, rsp_chan.target_position,
                  rsp_chan.target_speed, rsp_chan.lamp_off, rsp_chan.last)});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] mid_lower;
      reset                    = 1'b1;
      psel                     = 1'b0;
      penable                  = 1'b0;
      pwrite                   = 1'b0;
      paddr                    = '0;
      pwdata                   = '0;
      req_chan.valid           = 1'b0;
      req_chan.rx_byte         = '0;
      req_chan.actual_position = '0;
      rsp_chan.ready           = 1'b0;
      steady                   = 1'b0;
      long_stall_armed         = 1'b0;
      lower_limit              = LOWER_RESET;
      upper_limit              = UPPER_RESET;
      frame_open               = 1'b0;
      frame_len                = '0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      bytes_queued             = 0;
      bytes_taken              = 0;
      frames_closed            = 0;
      init_frames              = 0;
      commands_checked         = 0;
      mismatches               = 0;
      idle_cycles              = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle bytes, a full frame with overflow, then a short frame that reuses old entries
      queue_byte(8'h00, 32'h0000_0000);
      queue_byte(8'hFF, 32'hFFFF_FFFF);
      queue_byte(SOF_BYTE, $urandom);
      foreach (LONG_FRAME[i]) queue_byte(LONG_FRAME[i], $urandom);
      queue_byte(EOF_BYTE, LOWER_RESET + 32'd3);
      queue_byte(SOF_BYTE, $urandom);
      queue_byte(INIT_BYTE, $urandom);
      queue_byte(EOF_BYTE, 32'h0000_0000);
      @(posedge clock);
      long_stall_armed <= 1'b1;
      queue_frames(30, 2);
      drain();

      set_limit(LOWER_ADDR, 32'h0000_0000);
      set_limit(UPPER_ADDR, 32'hFFFF_FFFF);
      queue_frames(12, 1);
      drain();

      mid_lower = $urandom_range(0, 32'h0010_0000);
      set_limit(LOWER_ADDR, mid_lower);
      set_limit(UPPER_ADDR, mid_lower + 32'($urandom_range(1, 200000)));
      steady <= 1'b1;
      queue_frames(12, 1);
      drain();
      steady <= 1'b0;

      set_limit(LOWER_ADDR, 32'hFFFF_FFFF);
      set_limit(UPPER_ADDR, 32'h0000_0000);
      queue_frames(12, 1);
      drain();

      $display("Sent %0d bytes in %0d closed frames (%0d init), checked %0d results",
               bytes_taken, frames_closed, init_frames, commands_checked);
      $display("Limit settings: reset, widest, random window, inverted; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
design/gcfd_pkg.sv
design/gcfd_if.sv
design/gcfd_front.sv
design/gcfd_queue.sv
design/gcfd_back.sv
design/gimbal_command_frame_decoder.sv
verif/tb_gimbal_command_frame_decoder.sv
